// ===== hdl/tmp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tmp_pkg;

  localparam int SCREEN_W_DEF = 320;
  localparam int SCREEN_H_DEF = 200;

  localparam int RCP_W = 13;
  localparam logic [14:0] ENEMY_ZMIN = 15'd40;
  localparam logic [14:0] PEER_ZMIN = 15'd512;
  localparam logic [14:0] ZMAX = 15'd8192;
  localparam logic signed [15:0] MARK_W = 16'sd6144;
  localparam logic signed [15:0] MIN_HALF = 16'sd3;
  localparam int XLO = 1;
  localparam int XHI = 319;
  localparam int YLO = 1;
  localparam int YHI = 199;

  localparam logic [1:0] CFG_CAMERA_X = 2'd0;
  localparam logic [1:0] CFG_CAMERA_Y = 2'd1;

  typedef struct packed {
    logic              command;
    logic signed [15:0] world_x;
    logic [14:0]       depth;
    logic signed [15:0] altitude;
  } req_t;

  typedef struct packed {
    logic [8:0] start_x;
    logic [7:0] start_y;
    logic [8:0] end_x;
    logic [7:0] end_y;
    logic       last_segment;
  } seg_t;

  typedef struct packed {
    logic [8:0] tx;
    logic [7:0] ty;
    logic [8:0] lx;
    logic [7:0] ly;
    logic [8:0] rx;
  } tri_t;

  // floor(a*b/1024) wrapped to 16 bits; arithmetic shift floors
  function automatic logic signed [15:0] fmul(input logic signed [31:0] p);
    logic signed [31:0] q;
    q = p >>> 10;
    return q[15:0];
  endfunction

  function automatic logic [8:0] clamp_x(input logic signed [15:0] v);
    logic [8:0] r;
    if (v < 16'(XLO)) r = 9'(XLO);
    else if (v > 16'(XHI)) r = 9'(XHI);
    else r = v[8:0];
    return r;
  endfunction

  function automatic logic [7:0] clamp_y(input logic signed [15:0] v);
    logic [7:0] r;
    if (v < 16'(YLO)) r = 8'(YLO);
    else if (v > 16'(YHI)) r = 8'(YHI);
    else r = v[7:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/triangle_marker_project_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Projects one triangle marker per request into three clamped screen segments.
// A request enters a seven stage pipeline (depth check, 131072/z divide over
// three stages, three fixed-point products, position and size, cull and clamp)
// and can enter every cycle unless in_stall holds the pipeline while a finished
// triangle waits for the busy segment emitter; the emitter sends the three
// segments one after another through the single output port, which bounds the
// rate of visible markers. Culled markers never reach the emitter.
module triangle_marker_project_core #(
  parameter int SCREEN_W = tmp_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = tmp_pkg::SCREEN_H_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire tmp_pkg::req_t in_req,
  output logic               out_valid,
  input  wire logic          out_stall,
  output tmp_pkg::seg_t      out_seg
);
  import tmp_pkg::*;

  logic signed [15:0] camera_x, camera_y;
  logic tv, ts, en;
  tri_t tr;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x <= 16'sd512;
      camera_y <= 16'sd2048;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CAMERA_X) camera_x <= cfg_data;
      if (cfg_index == CFG_CAMERA_Y) camera_y <= cfg_data;
    end
  end

  assign en = !(tv && ts);
  assign in_stall = !en;

  tmp_geom #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_geom (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid), .in_req(in_req),
    .camera_x(camera_x), .camera_y(camera_y), .out_valid(tv), .out_tri(tr)
  );

  tmp_emit u_emit (
    .clk(clk), .rst(rst), .tri_valid(tv), .tri_in(tr), .tri_stall(ts),
    .seg_valid(out_valid), .seg(out_seg), .seg_stall(out_stall)
  );
endmodule
`default_nettype wire

// ===== hdl/tmp_rcp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tmp_rcp (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [14:0]          z,
  output logic [tmp_pkg::RCP_W-1:0] rcp
);
  import tmp_pkg::*;

  // 131072/z by restoring division, six quotient steps per stage,
  // registered after each stage in rem1/q1, rem2/q2 and rcp
  logic [17:0]      rem_a, rem_b, rem_c;
  logic [RCP_W-1:0] q_a, q_b, q_c;
  logic [17:0]      trial_a, trial_b, trial_c;
  logic [17:0]      rem1, rem2;
  logic [RCP_W-1:0] q1, q2;
  logic [14:0]      z1, z2;

  always_comb begin
    rem_a = 18'd0;
    q_a = '0;
    trial_a = 18'd0;
    for (int i = 17; i >= 12; i--) begin
      rem_a = {rem_a[16:0], (i == 17) ? 1'b1 : 1'b0};
      trial_a = rem_a - {3'd0, z};
      if (!trial_a[17]) begin
        rem_a = trial_a;
        if (i == 12) q_a[12] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem1 <= rem_a;
      q1 <= q_a;
      z1 <= z;
    end
  end

  always_comb begin
    rem_b = rem1;
    q_b = q1;
    trial_b = 18'd0;
    for (int i = 11; i >= 6; i--) begin
      rem_b = {rem_b[16:0], 1'b0};
      trial_b = rem_b - {3'd0, z1};
      if (!trial_b[17]) begin
        rem_b = trial_b;
        q_b[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem2 <= rem_b;
      q2 <= q_b;
      z2 <= z1;
    end
  end

  always_comb begin
    rem_c = rem2;
    q_c = q2;
    trial_c = 18'd0;
    for (int i = 5; i >= 0; i--) begin
      rem_c = {rem_c[16:0], 1'b0};
      trial_c = rem_c - {3'd0, z2};
      if (!trial_c[17]) begin
        rem_c = trial_c;
        q_c[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rcp <= q_c;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/tmp_geom.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tmp_geom #(
  parameter int SCREEN_W = tmp_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = tmp_pkg::SCREEN_H_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire tmp_pkg::req_t      in_req,
  input  wire logic signed [15:0] camera_x,
  input  wire logic signed [15:0] camera_y,
  output logic                    out_valid,
  output tmp_pkg::tri_t           out_tri
);
  import tmp_pkg::*;

  localparam logic signed [15:0] CX = 16'(SCREEN_W / 2);
  localparam logic signed [15:0] CY = 16'(SCREEN_H / 2);

  // stage 1: depth check, differences
  logic [14:0] z1;
  logic               v1, up1;
  logic signed [15:0] dx1, dy1;
  logic [14:0] zs;
  logic ok;

  always_comb begin
    zs = in_req.depth;
    ok = 1'b1;
    if (in_req.command) begin
      if (zs < PEER_ZMIN) zs = PEER_ZMIN;
      if (zs > ZMAX) zs = ZMAX;
    end else if (zs < ENEMY_ZMIN || zs > ZMAX) begin
      ok = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid && ok;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1 <= zs;
      up1 <= in_req.command;
      dx1 <= in_req.world_x - camera_x;
      dy1 <= camera_y - in_req.altitude;
    end
  end

  // stage 2: reciprocal, with valid and operands delayed alongside the divider
  logic [RCP_W-1:0] rcp2;
  logic v2, up2, v2a, up2a, v2b, up2b;
  logic signed [15:0] dx2, dy2, dx2a, dy2a, dx2b, dy2b;

  tmp_rcp u_rcp (.clk(clk), .en(en), .z(z1), .rcp(rcp2));

  always_ff @(posedge clk) begin
    if (rst) begin
      v2a <= 1'b0;
      v2b <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v2a <= v1;
      v2b <= v2a;
      v2 <= v2b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      up2a <= up1;
      dx2a <= dx1;
      dy2a <= dy1;
      up2b <= up2a;
      dx2b <= dx2a;
      dy2b <= dy2a;
      up2 <= up2b;
      dx2 <= dx2b;
      dy2 <= dy2b;
    end
  end

  // stage 3: products
  logic v3, up3;
  logic signed [15:0] mx3, my3, mw3;
  logic signed [31:0] rs;

  assign rs = 32'($signed({1'b0, rcp2}));

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      up3 <= up2;
      mx3 <= fmul(rs * 32'(dx2));
      my3 <= fmul(rs * 32'(dy2));
      mw3 <= fmul(rs * 32'(MARK_W));
    end
  end

  // stage 4: screen position and size
  logic v4, up4;
  logic signed [15:0] sx4, sy4, hw4, hh4;
  logic signed [15:0] hwc, hhc;

  always_comb begin
    hwc = mw3 >>> 7;
    if (hwc < MIN_HALF) hwc = MIN_HALF;
    hhc = hwc - (hwc >>> 3) - (hwc >>> 7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      up4 <= up3;
      sx4 <= CX + mx3;
      sy4 <= up3 ? CY + my3 : CY;
      hw4 <= hwc;
      hh4 <= hhc;
    end
  end

  // stage 5: cull and clamp
  logic signed [16:0] sxe, sye, hwe, hhe;
  logic vis;
  logic signed [15:0] d;

  always_comb begin
    sxe = 17'(sx4);
    sye = 17'(sy4);
    hwe = 17'(hw4);
    hhe = 17'(hh4);
    vis = !(sxe - hwe > 17'sd319 || sxe + hwe < 17'sd1 ||
            sye - hhe > 17'sd199 || sye + hhe < 17'sd1);
    d = up4 ? -hh4 : hh4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v4 && vis;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tri.tx <= clamp_x(sx4);
      out_tri.ty <= clamp_y(sy4 + d);
      out_tri.lx <= clamp_x(sx4 - hw4);
      out_tri.ly <= clamp_y(sy4 - d);
      out_tri.rx <= clamp_x(sx4 + hw4);
    end
  end
endmodule
`default_nettype wire

// ===== hdl/tmp_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tmp_emit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          tri_valid,
  input  wire tmp_pkg::tri_t tri_in,
  output logic               tri_stall,
  output logic               seg_valid,
  output tmp_pkg::seg_t      seg,
  input  wire logic          seg_stall
);
  import tmp_pkg::*;

  logic       busy;
  logic [1:0] idx;
  tri_t       cur;
  logic       take;
  logic       done;

  assign done = busy && !seg_stall && idx == 2'd2;
  assign tri_stall = busy && !done;
  assign take = tri_valid && !tri_stall;
  assign seg_valid = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= 2'd0;
    end else if (take) begin
      busy <= 1'b1;
      idx <= 2'd0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy && !seg_stall) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= tri_in;
    end
  end

  always_comb begin
    unique case (idx)
      2'd0:    seg = '{cur.tx, cur.ty, cur.lx, cur.ly, 1'b0};
      2'd1:    seg = '{cur.lx, cur.ly, cur.rx, cur.ly, 1'b0};
      default: seg = '{cur.rx, cur.ly, cur.tx, cur.ty, 1'b1};
    endcase
  end
endmodule
`default_nettype wire

// ===== tb/sv/triangle_marker_project_core_test.sv =====
`timescale 1ns / 1ps
module triangle_marker_project_core_test;
  import tmp_pkg::*;

  class segment_scoreboard;
    seg_t pending[$];
    int   errors;
    logic signed [15:0] cam_x = 16'sd512;
    logic signed [15:0] cam_y = 16'sd2048;

    function automatic int scale(int a, int b);
      int p;
      int q;
      p = a * b;
      q = p >>> 10;
      return int'($signed(q[15:0]));
    endfunction

    function automatic int w16(int v);
      return int'($signed(v[15:0]));
    endfunction

    function automatic int clip(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void note_request(req_t r);
      int z, rcp, sx, sy, hw, hh, d, tx, ty, lx, ly, rx;
      seg_t s;
      z = int'(r.depth);
      if (r.command) begin
        if (z < 512) z = 512;
        if (z > 8192) z = 8192;
      end else if (z < 40 || z > 8192) begin
        return;
      end
      rcp = 131072 / z;
      if (r.command) sy = w16(100 + scale(rcp, w16(int'(cam_y) - int'(r.altitude))));
      else sy = 100;
      sx = w16(160 + scale(rcp, w16(int'(r.world_x) - int'(cam_x))));
      hw = w16(scale(rcp, 6144) >>> 7);
      if (hw < 3) hw = 3;
      hh = w16(hw - (hw >>> 3) - (hw >>> 7));
      if (sx - hw > 319 || sx + hw < 1 || sy - hh > 199 || sy + hh < 1) return;
      d = r.command ? w16(-hh) : hh;
      tx = clip(sx, 1, 319);
      ty = clip(w16(sy + d), 1, 199);
      lx = clip(w16(sx - hw), 1, 319);
      ly = clip(w16(sy - d), 1, 199);
      rx = clip(w16(sx + hw), 1, 319);
      s = '{9'(tx), 8'(ty), 9'(lx), 8'(ly), 1'b0};
      pending.push_back(s);
      s = '{9'(lx), 8'(ly), 9'(rx), 8'(ly), 1'b0};
      pending.push_back(s);
      s = '{9'(rx), 8'(ly), 9'(tx), 8'(ty), 1'b1};
      pending.push_back(s);
    endfunction

    function void check_segment(seg_t got);
      seg_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected segment %h", got);
        return;
      end
      want = pending.pop_front();
      if (want.start_x !== got.start_x || want.start_y !== got.start_y ||
          want.end_x !== got.end_x || want.end_y !== got.end_y ||
          want.last_segment !== got.last_segment) begin
        errors++;
        if (errors <= 10) $display("segment mismatch expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_CAMERA_X;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  seg_t out_seg;
  segment_scoreboard board;
  int cycles = 0;
  int stall_left = 0;

  triangle_marker_project_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_seg(out_seg)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("status: fail");
      $finish;
    end
    if (!rst && out_valid && !out_stall) board.check_segment(out_seg);
  end

  // receiver stalls a random stretch before each segment, some runs without stalls
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) stall_left = ($urandom_range(0, 3) == 0) ? 0
        : $urandom_range(0, 18);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic write_camera(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CAMERA_X) board.cam_x = val;
    else board.cam_y = val;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // valid stays high after an accepted request until the next call or a drain
  task automatic send_request(req_t r, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(r);
    @(negedge clk);
  endtask

  function automatic req_t random_request();
    req_t r;
    r.command = 1'($urandom_range(0, 1));
    r.world_x = 16'($urandom);
    r.altitude = 16'($urandom);
    case ($urandom_range(0, 5))
      0: r.depth = 15'($urandom);
      1: r.depth = 15'($urandom_range(0, 600));
      default: r.depth = 15'($urandom_range(40, 8192));
    endcase
    if ($urandom_range(0, 3) != 0) begin
      r.world_x = 16'(int'(board.cam_x) + $signed(16'($urandom_range(0, 8000))) - 4000);
      r.altitude = 16'(int'(board.cam_y) + $signed(16'($urandom_range(0, 6000))) - 3000);
    end
    return r;
  endfunction

  function automatic int random_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  initial begin
    req_t r;
    logic [15:0] cams [4];
    cams = '{16'h8000, 16'h7fff, 16'h0000, 16'h0200};
    board = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_request('{1'b0, 16'sd512, 15'd1024, 16'sd0}, 0);
    send_request('{1'b1, 16'sd512, 15'd1024, 16'sd2048}, 0);
    send_request('{1'b0, 16'sd512, 15'd39, 16'sd0}, 0);
    send_request('{1'b0, 16'sd512, 15'd40, 16'sd0}, 0);
    send_request('{1'b0, 16'sd512, 15'd8192, 16'sd0}, 0);
    send_request('{1'b0, 16'sd512, 15'd8193, 16'sd0}, 1);
    send_request('{1'b1, 16'sd512, 15'd0, 16'sd2048}, 0);
    send_request('{1'b1, 16'sd512, 15'd32767, 16'sd2048}, 0);
    send_request('{1'b1, 16'sd512, 15'd511, 16'sh7fff}, 0);
    send_request('{1'b1, 16'sd512, 15'd600, -16'sd32768}, 0);
    send_request('{1'b0, 16'sh7fff, 15'd40, 16'sh7fff}, 0);
    send_request('{1'b0, -16'sd32768, 15'd40, -16'sd32768}, 0);
    send_request('{1'b0, 16'sd700, 15'd2000, 16'sd0}, 2);
    send_request('{1'b0, 16'sd300, 15'd2000, 16'sd0}, 0);
    send_request('{1'b1, 16'sd512, 15'd8192, 16'sd0}, 0);
    drain();
    for (int p = 0; p < 5; p++) begin
      write_camera(CFG_CAMERA_X, p < 4 ? cams[p] : 16'($urandom));
      write_camera(CFG_CAMERA_Y, p < 4 ? cams[3 - p] : 16'($urandom));
      for (int i = 0; i < 92; i++) begin
        if (i == 46) drain();
        r = random_request();
        send_request(r, random_gap());
      end
      drain();
    end
    if (board.errors == 0 && board.pending.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/tmp_pkg.sv
hdl/tmp_rcp.sv
hdl/tmp_geom.sv
hdl/tmp_emit.sv
hdl/triangle_marker_project_core.sv
tb/sv/triangle_marker_project_core_test.sv
